@@ sv/ilst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

	// default geometry of the list
	localparam int DEPTH_DEF = 64;
	localparam int WIDTH_DEF = 32;

	// fixed port widths
	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 7;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// request codes
	typedef enum logic [KIND_W-1:0] {
		KIND_GET    = 2'd0,
		KIND_SET    = 2'd1,
		KIND_INSERT = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// broadcast from the controller to the row of cells and the result register
	typedef struct packed {
		cell_op_t op;
		status_t  status;
		logic     rd_hit;
	} ctl_t;

endpackage

`default_nettype wire

@@ sv/ilst_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ilst_cell #(
	parameter int IDX   = 0,
	parameter int WIDTH = ilst_pkg::WIDTH_DEF,
	parameter int PW    = 6
) (
	input  wire logic                 clk,
	input  wire ilst_pkg::cell_op_t   op,
	input  wire logic [PW-1:0]        pos,
	input  wire logic [WIDTH-1:0]     word,
	input  wire logic [WIDTH-1:0]     left,
	input  wire logic [WIDTH-1:0]     right,
	output logic      [WIDTH-1:0]     word_q
);

	localparam logic [PW-1:0] IDX_P = PW'(IDX);

	logic [WIDTH-1:0] word_d;

	// pick own word, new word or a neighbour's
	always_comb begin
		word_d = word_q;
		case (op)
			ilst_pkg::CELL_WRITE: begin
				if (IDX_P == pos) word_d = word;
			end
			ilst_pkg::CELL_INSERT: begin
				if (IDX_P == pos) word_d = word;
				else if (IDX_P > pos) word_d = left;
			end
			ilst_pkg::CELL_REMOVE: begin
				if (IDX_P >= pos) word_d = right;
			end
			default: word_d = word_q;
		endcase
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule

`default_nettype wire

@@ sv/ilst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ilst_ctrl #(
	parameter int DEPTH = ilst_pkg::DEPTH_DEF,
	parameter int CW    = 7,
	parameter int PW    = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [ilst_pkg::KIND_W-1:0]  kind,
	input  wire logic [ilst_pkg::INDEX_W-1:0] index,
	output ilst_pkg::ctl_t                    ctl,
	output logic      [PW-1:0]                pos,
	output logic      [CW-1:0]                count_n,
	output logic      [CW-1:0]                cap_n
);

	localparam int CMPW = (CW > ilst_pkg::INDEX_W) ? CW : ilst_pkg::INDEX_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [CW-1:0]   count_q, cap_q;
	logic [CMPW-1:0] idx_x, cnt_x;
	logic            lt, eq, full;
	logic [CW:0]     grown;
	logic [CW-1:0]   cap_ins, cap_rem, cnt_dec;
	ilst_pkg::kind_t kind_e;

	assign kind_e = ilst_pkg::kind_t'(kind);
	assign idx_x  = CMPW'(index);
	assign cnt_x  = CMPW'(count_q);
	assign lt     = idx_x < cnt_x;
	assign eq     = idx_x == cnt_x;
	assign full   = count_q == DEPTH_C;
	assign pos    = idx_x[PW-1:0];

	// capacity after a growing insert, saturating at the depth
	assign grown   = {1'b0, cap_q} << 1;
	assign cap_ins = (cap_q != count_q) ? cap_q :
	                 (grown > DEPTH_X) ? DEPTH_C : grown[CW-1:0];

	// capacity after a remove: halve below a quarter, back to one when empty
	assign cnt_dec = count_q - ONE_C;
	always_comb begin
		cap_rem = cap_q;
		if (cnt_dec < (cap_q >> 2)) cap_rem = cap_q >> 1;
		if (cnt_dec == '0) cap_rem = ONE_C;
	end

	// request decode
	always_comb begin
		ctl.op     = ilst_pkg::CELL_HOLD;
		ctl.status = ilst_pkg::ST_OK;
		ctl.rd_hit = 1'b0;
		unique case (kind_e)
			ilst_pkg::KIND_GET: begin
				if (lt) ctl.rd_hit = 1'b1;
				else ctl.status = ilst_pkg::ST_RANGE;
			end
			ilst_pkg::KIND_SET: begin
				if (lt) begin
					ctl.op     = ilst_pkg::CELL_WRITE;
					ctl.rd_hit = 1'b1;
				end else if (!eq) ctl.status = ilst_pkg::ST_RANGE;
				else if (full) ctl.status = ilst_pkg::ST_FULL;
				else ctl.op = ilst_pkg::CELL_INSERT;
			end
			ilst_pkg::KIND_INSERT: begin
				if (!(lt || eq)) ctl.status = ilst_pkg::ST_RANGE;
				else if (full) ctl.status = ilst_pkg::ST_FULL;
				else ctl.op = ilst_pkg::CELL_INSERT;
			end
			ilst_pkg::KIND_REMOVE: begin
				if (lt) begin
					ctl.op     = ilst_pkg::CELL_REMOVE;
					ctl.rd_hit = 1'b1;
				end else ctl.status = ilst_pkg::ST_RANGE;
			end
			default: ctl.status = ilst_pkg::ST_RANGE;
		endcase
		if (!accept) ctl.op = ilst_pkg::CELL_HOLD;
	end

	// count and capacity after this item
	always_comb begin
		count_n = count_q;
		cap_n   = cap_q;
		case (ctl.op)
			ilst_pkg::CELL_INSERT: begin
				count_n = count_q + ONE_C;
				cap_n   = cap_ins;
			end
			ilst_pkg::CELL_REMOVE: begin
				count_n = cnt_dec;
				cap_n   = cap_rem;
			end
			default: begin
				count_n = count_q;
				cap_n   = cap_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= ONE_C;
		end else if (accept) begin
			count_q <= count_n;
			cap_q   <= cap_n;
		end
	end

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above modelled capacity");

	a_cap_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q <= DEPTH_C && cap_q != '0)
		else $error("capacity out of range");

	a_full_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.status == ilst_pkg::ST_FULL |-> count_q == DEPTH_C)
		else $error("full flagged on a list with room");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.op == ilst_pkg::CELL_INSERT |=> count_q == $past(count_q) + ONE_C)
		else $error("insert did not grow the count");

endmodule

`default_nettype wire

@@ sv/indexed_shift_insert_list_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH words held in a row of cells, one word per cell. Each
// accepted item (get, set, insert or remove at an index) is decoded and applied to
// every cell in the cycle it is accepted: on insert the cell at the index takes the
// new word, cells above it their lower neighbour; on remove cells at and above it
// their upper one, at any length. One result per item appears in the output register
// on the next cycle; a new item is taken every cycle while that register is empty or
// being drained, giving one item per cycle sustained. The removed, read or replaced
// word comes from a read select across the row; bad indices and inserts into a full
// list are flagged with status and leave the list untouched.
module indexed_shift_insert_list_core #(
	parameter int DEPTH = ilst_pkg::DEPTH_DEF,
	parameter int WIDTH = ilst_pkg::WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ilst_pkg::KIND_W-1:0]   kind,
	input  wire logic [ilst_pkg::INDEX_W-1:0]  index,
	input  wire logic [ilst_pkg::VALUE_W-1:0]  value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ilst_pkg::VALUE_W-1:0]  old_value,
	output logic      [ilst_pkg::COUNT_W-1:0]  count,
	output logic      [ilst_pkg::COUNT_W-1:0]  capacity,
	output logic      [ilst_pkg::STATUS_W-1:0] status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);

	logic                   accept;
	logic                   out_valid_q;
	ilst_pkg::ctl_t         ctl;
	logic [PW-1:0]          pos;
	logic [CW-1:0]          count_n, cap_n;
	logic [WIDTH-1:0]       word;
	logic [WIDTH-1:0]       cell_word [DEPTH];
	logic [63:0]            rd_wide;
	logic [ilst_pkg::VALUE_W-1:0] old_value_q;
	logic [ilst_pkg::COUNT_W-1:0] count_q, capacity_q;
	ilst_pkg::status_t      status_q;

	// single output register; take an item whenever it is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign word     = WIDTH'(value);

	ilst_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.PW    (PW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.index   (index),
		.ctl     (ctl),
		.pos     (pos),
		.count_n (count_n),
		.cap_n   (cap_n)
	);

	// row of cells, end cells see themselves past the edge
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] left, right;
		assign left  = (i == 0) ? cell_word[i] : cell_word[(i == 0) ? 0 : i - 1];
		assign right = (i == DEPTH - 1) ? cell_word[i] :
		               cell_word[(i == DEPTH - 1) ? i : i + 1];
		ilst_cell #(
			.IDX   (i),
			.WIDTH (WIDTH),
			.PW    (PW)
		) u_cell (
			.clk    (clk),
			.op     (ctl.op),
			.pos    (pos),
			.word   (word),
			.left   (left),
			.right  (right),
			.word_q (cell_word[i])
		);
	end

	// word at the index, before this item changes the row
	assign rd_wide = 64'(cell_word[pos]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			old_value_q <= ctl.rd_hit ? rd_wide[ilst_pkg::VALUE_W-1:0] : '0;
			count_q     <= ilst_pkg::COUNT_W'(count_n);
			capacity_q  <= ilst_pkg::COUNT_W'(cap_n);
			status_q    <= ctl.status;
		end
	end

	assign out_valid = out_valid_q;
	assign old_value = old_value_q;
	assign count     = count_q;
	assign capacity  = capacity_q;
	assign status    = status_q;

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count) && $stable(old_value))
		else $error("stalled result changed");

	a_flag_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.status != ilst_pkg::ST_OK |-> ctl.op == ilst_pkg::CELL_HOLD && !ctl.rd_hit)
		else $error("flagged item touched the list");

endmodule

`default_nettype wire

@@ sim/indexed_shift_insert_list_core_tb.sv @@
`timescale 1ns / 1ps

module indexed_shift_insert_list_core_tb;

	localparam int DEPTH      = ilst_pkg::DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;

	// one result as the block reports it
	typedef struct packed {
		logic [ilst_pkg::VALUE_W-1:0] old_value;
		logic [ilst_pkg::COUNT_W-1:0] count;
		logic [ilst_pkg::COUNT_W-1:0] capacity;
		ilst_pkg::status_t            status;
	} list_result_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		ilst_pkg::kind_t              op;
		logic [ilst_pkg::INDEX_W-1:0] idx;
		logic [ilst_pkg::VALUE_W-1:0] val;
		bit                           typed;
		list_result_t                 want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [ilst_pkg::KIND_W-1:0]   kind;
	logic [ilst_pkg::INDEX_W-1:0]  index;
	logic [ilst_pkg::VALUE_W-1:0]  value;
	logic                          out_valid;
	logic                          out_ready;
	logic [ilst_pkg::VALUE_W-1:0]  old_value;
	logic [ilst_pkg::COUNT_W-1:0]  count;
	logic [ilst_pkg::COUNT_W-1:0]  capacity;
	logic [ilst_pkg::STATUS_W-1:0] status;

	// shadow copy of the list
	logic [ilst_pkg::VALUE_W-1:0] shadow_slots [DEPTH];
	int                           shadow_count;
	int                           shadow_cap;

	list_result_t pending_results [$];
	dir_row_t     dir_rows [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fails;
	int n_sent;
	int n_directed;
	int n_checked;
	int n_range;
	int n_full;
	int quiet_cycles;

	indexed_shift_insert_list_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.old_value (old_value),
		.count     (count),
		.capacity  (capacity),
		.status    (status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// place a word at pos, growing the modelled capacity when full
	function automatic void shadow_put(int pos, logic [ilst_pkg::VALUE_W-1:0] word);
		if (shadow_cap == shadow_count)
			shadow_cap = (shadow_cap * 2 > DEPTH) ? DEPTH : shadow_cap * 2;
		for (int i = shadow_count; i > pos; i--)
			shadow_slots[i] = shadow_slots[i-1];
		shadow_slots[pos] = word;
		shadow_count++;
	endfunction

	// apply one request to the shadow list and return what the block should answer
	function automatic list_result_t list_apply(ilst_pkg::kind_t op,
			logic [ilst_pkg::INDEX_W-1:0] idx, logic [ilst_pkg::VALUE_W-1:0] word);
		list_result_t res;
		int           pos;
		pos = idx;
		res.old_value = '0;
		res.status    = ilst_pkg::ST_OK;
		case (op)
			ilst_pkg::KIND_GET: begin
				if (pos < shadow_count)
					res.old_value = shadow_slots[pos];
				else
					res.status = ilst_pkg::ST_RANGE;
			end
			ilst_pkg::KIND_SET: begin
				if (pos < shadow_count) begin
					res.old_value = shadow_slots[pos];
					shadow_slots[pos] = word;
				end else if (pos > shadow_count) begin
					res.status = ilst_pkg::ST_RANGE;
				end else if (shadow_count >= DEPTH) begin
					res.status = ilst_pkg::ST_FULL;
				end else begin
					shadow_put(pos, word);
				end
			end
			ilst_pkg::KIND_INSERT: begin
				if (pos > shadow_count)
					res.status = ilst_pkg::ST_RANGE;
				else if (shadow_count >= DEPTH)
					res.status = ilst_pkg::ST_FULL;
				else
					shadow_put(pos, word);
			end
			default: begin
				// remove: close the gap, then shrink the capacity
				if (pos < shadow_count) begin
					res.old_value = shadow_slots[pos];
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_slots[i] = shadow_slots[i+1];
					shadow_count--;
					if (shadow_count < shadow_cap / 4)
						shadow_cap = shadow_cap / 2;
					if (shadow_count == 0)
						shadow_cap = 1;
				end else begin
					res.status = ilst_pkg::ST_RANGE;
				end
			end
		endcase
		res.count    = shadow_count[ilst_pkg::COUNT_W-1:0];
		res.capacity = shadow_cap[ilst_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// offer one item, wait for it to be taken, then queue its expected result
	task automatic send_item(input ilst_pkg::kind_t op,
			input logic [ilst_pkg::INDEX_W-1:0] idx,
			input logic [ilst_pkg::VALUE_W-1:0] word, input bit typed,
			input list_result_t want);
		list_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		index    <= idx;
		value    <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = list_apply(op, idx, word);
		pending_results.push_back(typed ? want : predicted);
		n_sent++;
	endtask

	// random request; grow_pct and shrink_pct bias the list towards full or empty
	task automatic random_item(input int grow_pct, input int shrink_pct);
		int              r;
		int              pos;
		ilst_pkg::kind_t op;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// noise: anything the fields allow
			op  = ilst_pkg::kind_t'($urandom_range(0, 3));
			pos = $urandom_range(0, 127);
		end else if (r < 10 + grow_pct) begin
			op  = ($urandom_range(0, 3) == 0) ? ilst_pkg::KIND_SET : ilst_pkg::KIND_INSERT;
			pos = (op == ilst_pkg::KIND_SET) ? shadow_count : $urandom_range(0, shadow_count);
		end else if (r < 10 + grow_pct + shrink_pct) begin
			op  = ilst_pkg::KIND_REMOVE;
			pos = (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
		end else begin
			op  = $urandom_range(0, 1) ? ilst_pkg::KIND_SET : ilst_pkg::KIND_GET;
			pos = (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
		end
		send_item(op, pos[ilst_pkg::INDEX_W-1:0], $urandom(), 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [ilst_pkg::VALUE_W-1:0] want,
			input logic [ilst_pkg::VALUE_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// result side: random back-pressure and comparison with the oldest expectation
	initial begin
		list_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				n_checked++;
				if (status == ilst_pkg::ST_RANGE)
					n_range++;
				if (status == ilst_pkg::ST_FULL)
					n_full++;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: old_value 0x%0h status %0d",
						old_value, status);
					fails++;
				end else begin
					want = pending_results.pop_front();
					check_field("old_value", want.old_value, old_value);
					check_field("count", ilst_pkg::VALUE_W'(want.count),
						ilst_pkg::VALUE_W'(count));
					check_field("capacity", ilst_pkg::VALUE_W'(want.capacity),
						ilst_pkg::VALUE_W'(capacity));
					check_field("status", ilst_pkg::VALUE_W'(want.status),
						ilst_pkg::VALUE_W'(status));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int       fulls;
		dir_row_t row;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = ilst_pkg::KIND_GET;
		index         = '0;
		value         = '0;
		out_ready     = 1'b0;
		fails         = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_range       = 0;
		n_full        = 0;
		shadow_count  = 0;
		shadow_cap    = 1;
		send_idle_pct = 31;
		recv_idle_pct = 74;

		// directed table: empty list, bad indices, growth and shrink of the capacity
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd0, 32'h0, 1,
			'{32'h0, 7'd0, 7'd1, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd0, 32'h0, 1,
			'{32'h0, 7'd0, 7'd1, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_SET, 7'd1, 32'h1, 1,
			'{32'h0, 7'd0, 7'd1, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd127, 32'h2, 1,
			'{32'h0, 7'd0, 7'd1, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd0, 32'hFFFFFFFF, 1,
			'{32'h0, 7'd1, 7'd1, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_SET, 7'd1, 32'h0, 1,
			'{32'h0, 7'd2, 7'd2, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd1, 32'hA5A5A5A5, 1,
			'{32'h0, 7'd3, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd0, 32'h0, 1,
			'{32'hFFFFFFFF, 7'd3, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd2, 32'h0, 1,
			'{32'h0, 7'd3, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd3, 32'h0, 1,
			'{32'h0, 7'd3, 7'd4, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_SET, 7'd1, 32'h5A5A5A5A, 1,
			'{32'hA5A5A5A5, 7'd3, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd3, 32'h12345678, 1,
			'{32'h0, 7'd4, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd0, 32'h80000000, 1,
			'{32'h0, 7'd5, 7'd8, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_SET, 7'd6, 32'h3, 1,
			'{32'h0, 7'd5, 7'd8, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd5, 32'h0, 1,
			'{32'h0, 7'd5, 7'd8, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd0, 32'h0, 1,
			'{32'h80000000, 7'd4, 7'd8, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd3, 32'h0, 1,
			'{32'h12345678, 7'd3, 7'd8, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd1, 32'h0, 1,
			'{32'h5A5A5A5A, 7'd2, 7'd8, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd1, 32'h0, 1,
			'{32'h0, 7'd1, 7'd4, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_REMOVE, 7'd0, 32'h0, 1,
			'{32'hFFFFFFFF, 7'd0, 7'd1, ilst_pkg::ST_OK}});
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd64, 32'h0, 1,
			'{32'h0, 7'd0, 7'd1, ilst_pkg::ST_RANGE}});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd0, 32'hDEADBEEF, 0, '0});
		dir_rows.push_back('{ilst_pkg::KIND_SET, 7'd0, 32'h00000001, 0, '0});
		dir_rows.push_back('{ilst_pkg::KIND_INSERT, 7'd1, 32'h7FFFFFFF, 0, '0});
		dir_rows.push_back('{ilst_pkg::KIND_GET, 7'd1, 32'h0, 0, '0});
		n_directed = dir_rows.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_item(row.op, row.idx, row.val, row.typed, row.want);
		end

		// random part in three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 74 : 0;
			recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 31 : 0;

			// fill until the list has sat full for a few requests
			fulls = 0;
			while (fulls < 6) begin
				if (shadow_count == DEPTH)
					fulls++;
				random_item(85, 5);
			end
			repeat (150) random_item(30, 25);

			// hold off until every outstanding result has come back
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);

			// drain to empty and a little past it
			while (shadow_count > 0)
				random_item(5, 80);
			repeat (10) random_item(5, 80);
			repeat (150) random_item(30, 25);
		end

		// let the last results come back
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests (%0d from the table) across three idling patterns,",
			n_sent, n_directed);
		$display("%0d results compared; list filled and drained each pattern, %0d bad-index, %0d full",
			n_checked, n_range, n_full);
		if (fails == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ilst_pkg.sv
sv/ilst_cell.sv
sv/ilst_ctrl.sv
sv/indexed_shift_insert_list_core.sv
sim/indexed_shift_insert_list_core_tb.sv
